[hw/rtl/pat_section_rewriter_core_defines.svh]
// ----------------------------------------------------------------------------
// pat_section_rewriter_core_defines
// Assertion macros for the PAT section rewriter.
// ----------------------------------------------------------------------------
`ifndef PAT_SECTION_REWRITER_CORE_DEFINES_SVH
`define PAT_SECTION_REWRITER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled in reset
`define PSR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("psr: same-cycle check failed");
// next-cycle implication, disabled in reset
`define PSR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("psr: next-cycle check failed");
`else
`define PSR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PSR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/psr_pkg.sv]
// ----------------------------------------------------------------------------
// psr_pkg
// Constants, register indexes and the CRC-32 byte update for the PAT rewriter.
// ----------------------------------------------------------------------------
package psr_pkg;

    // transport packet geometry
    localparam int unsigned PKT_LEN   = 188;
    localparam int unsigned POS_W     = 8;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PKT_LEN - 1);

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_SERVICE_ID = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PMT_PID    = 1'b1;

    // byte positions inside a rewritten PAT packet
    localparam logic [POS_W-1:0] POS_PID_HI    = 8'd1;
    localparam logic [POS_W-1:0] POS_PID_LO    = 8'd2;
    localparam logic [POS_W-1:0] POS_CRC_START = 8'd5;
    localparam logic [POS_W-1:0] POS_SEC_LEN_H = 8'd6;
    localparam logic [POS_W-1:0] POS_SEC_LEN_L = 8'd7;
    localparam logic [POS_W-1:0] POS_PROG0_H   = 8'd13;
    localparam logic [POS_W-1:0] POS_PROG0_L   = 8'd14;
    localparam logic [POS_W-1:0] POS_NIT_H     = 8'd15;
    localparam logic [POS_W-1:0] POS_NIT_L     = 8'd16;
    localparam logic [POS_W-1:0] POS_SVC_H     = 8'd17;
    localparam logic [POS_W-1:0] POS_SVC_L     = 8'd18;
    localparam logic [POS_W-1:0] POS_PMT_H     = 8'd19;
    localparam logic [POS_W-1:0] POS_PMT_L     = 8'd20;
    localparam logic [POS_W-1:0] POS_CRC_0     = 8'd21;
    localparam logic [POS_W-1:0] POS_CRC_1     = 8'd22;
    localparam logic [POS_W-1:0] POS_CRC_2     = 8'd23;
    localparam logic [POS_W-1:0] POS_CRC_3     = 8'd24;

    // fixed section bytes
    localparam logic [7:0] BYTE_SEC_LEN_H = 8'hb0;
    localparam logic [7:0] BYTE_SEC_LEN_L = 8'd17;
    localparam logic [7:0] BYTE_RESV_HI   = 8'he0;
    localparam logic [7:0] BYTE_NIT_PID_L = 8'h10;
    localparam logic [7:0] BYTE_STUFF     = 8'hff;

    // MPEG-2 CRC-32
    localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
    localparam logic [31:0] CRC_POLY = 32'h04c1_1db7;

    // one byte of CRC-32, MSB first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'd0};
        for (int i = 0; i < 8; i++) begin
            c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[hw/rtl/pat_section_rewriter_core.sv]
// From input accept to the earliest output accept a byte passes the input register
// and then the result register.
// Throughput: one byte per cycle while the output accepts; the CRC update and byte select sit in one stage.
// Stalls on the output side hold both stages; the input is ready while either frees.
// Reset (i_rst_n low, synchronous): both stages empty, position 0, CRC all ones,
// service_id and pmt_pid cleared.
// ----------------------------------------------------------------------------
// pat_section_rewriter_core
// Passes transport packets byte by byte; with a nonzero service id it replaces PID 0
// packets with a single-program PAT carrying the configured service id and PMT PID.
// ----------------------------------------------------------------------------
`include "pat_section_rewriter_core_defines.svh"

module pat_section_rewriter_core
    import psr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] in_byte
    input  logic                  i_s_tuser,   // [0] first_byte
    // output stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,   // [7:0] out_byte
    output logic                  o_m_tlast,   // last_byte
    output logic                  o_m_tuser    // [0] rewritten
);

    // configuration registers
    logic [15:0]      r_service_id;
    logic [12:0]      r_pmt_pid;

    // input stage
    logic             r_s1_valid;
    logic [7:0]       r_s1_byte;
    logic             r_s1_first;

    // packet state
    logic [POS_W-1:0] r_pos, n_pos;
    logic [4:0]       r_pid_hi, n_pid_hi;
    logic             r_active, n_active;
    logic [31:0]      r_crc, n_crc;

    // result stage
    logic             r_m_valid;
    logic [7:0]       r_m_byte;
    logic             r_m_last;
    logic             r_m_rewr;

    logic             out_free;
    logic             s1_adv;
    logic [POS_W-1:0] pos;
    logic [7:0]       ob;

    assign out_free   = !r_m_valid || i_m_tready;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_s_tready = !r_s1_valid || out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_service_id <= '0;
            r_pmt_pid    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SERVICE_ID: r_service_id <= i_cfg_wdata;
                CFG_PMT_PID:    r_pmt_pid    <= i_cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_s1_byte  <= i_s_tdata;
            r_s1_first <= i_s_tuser;
        end
    end

    // per-byte rewrite logic
    always_comb begin
        pos      = r_s1_first ? '0 : r_pos;
        if (pos >= POS_W'(PKT_LEN)) begin
            pos = '0;
        end
        n_pid_hi = r_pid_hi;
        n_active = r_active;
        n_crc    = r_crc;
        ob       = r_s1_byte;

        // packet start, PID capture, rewrite decision
        priority if (pos == '0) begin
            n_active = 1'b0;
            n_crc    = CRC_INIT;
        end else if (pos == POS_PID_HI) begin
            n_pid_hi = r_s1_byte[4:0];
        end else if (pos == POS_PID_LO) begin
            n_active = (r_pid_hi == '0) && (r_s1_byte == '0) && (r_service_id != '0);
        end else begin
        end

        // replacement bytes
        if (n_active) begin
            priority if (pos == POS_SEC_LEN_H) ob = BYTE_SEC_LEN_H;
            else if (pos == POS_SEC_LEN_L) ob = BYTE_SEC_LEN_L;
            else if (pos == POS_PROG0_H || pos == POS_PROG0_L) ob = '0;
            else if (pos == POS_NIT_H) ob = BYTE_RESV_HI;
            else if (pos == POS_NIT_L) ob = BYTE_NIT_PID_L;
            else if (pos == POS_SVC_H) ob = r_service_id[15:8];
            else if (pos == POS_SVC_L) ob = r_service_id[7:0];
            else if (pos == POS_PMT_H) ob = BYTE_RESV_HI | {3'b000, r_pmt_pid[12:8]};
            else if (pos == POS_PMT_L) ob = r_pmt_pid[7:0];
            else if (pos == POS_CRC_0) ob = r_crc[31:24];
            else if (pos == POS_CRC_1) ob = r_crc[23:16];
            else if (pos == POS_CRC_2) ob = r_crc[15:8];
            else if (pos == POS_CRC_3) ob = r_crc[7:0];
            else if (pos > POS_CRC_3) ob = BYTE_STUFF;
            else ob = r_s1_byte;

            // section CRC over bytes 5..20
            if (pos >= POS_CRC_START && pos <= POS_PMT_L) begin
                n_crc = crc32_byte(r_crc, ob);
            end
        end

        n_pos = (pos == POS_LAST) ? '0 : pos + 1'b1;
    end

    // packet state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_pid_hi <= '0;
            r_active <= 1'b0;
            r_crc    <= CRC_INIT;
        end else if (s1_adv) begin
            r_pos    <= n_pos;
            r_pid_hi <= n_pid_hi;
            r_active <= n_active;
            r_crc    <= n_crc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_free) begin
            r_m_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_m_byte <= ob;
            r_m_last <= (pos == POS_LAST);
            r_m_rewr <= n_active;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_byte;
    assign o_m_tlast  = r_m_last;
    assign o_m_tuser  = r_m_rewr;

    // checks
    `PSR_ASSERT_IMP(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos < POS_W'(PKT_LEN))
    `PSR_ASSERT_NXT(a_wrap_after_last, i_clk, i_rst_n, s1_adv && (pos == POS_LAST), r_pos == '0)
    `PSR_ASSERT_IMP(a_active_after_pid, i_clk, i_rst_n, r_active, (r_pos != 8'd1) && (r_pos != 8'd2))

endmodule

[dv/pat_section_rewriter_core_tb.sv]
// ----------------------------------------------------------------------------
// pat_section_rewriter_core_tb
// Self-checking bench for the PAT section rewriter. Transport packets go in
// byte by byte on the input stream. A cycle-free model of the rewrite (PID
// decode, section layout, MPEG-2 CRC-32) predicts every output item, and
// each output item is compared in order against that prediction. Directed
// packets cover the register extremes, decision timing, register changes
// in mid-packet and the start-mark corner cases. These are followed by a
// long randomized stream with random idling on both sides.
// ----------------------------------------------------------------------------
module pat_section_rewriter_core_tb;
    import psr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // expected output item
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       rewr;
    } t_pat_out;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = CFG_SERVICE_ID;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata = '0;   // [7:0] in_byte
    logic                  i_s_tuser = 1'b0; // [0] first_byte
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [7:0]            o_m_tdata;        // [7:0] out_byte
    logic                  o_m_tlast;        // last_byte
    logic                  o_m_tuser;        // [0] rewritten

    // model state and register copies
    logic [7:0]  pos_q = '0;
    logic [4:0]  pid_hi_q = '0;
    logic        rewriting_q = 1'b0;
    logic [31:0] crc_q = CRC_INIT;
    logic [15:0] svc_id_q = '0;
    logic [12:0] pmt_pid_q = '0;

    t_pat_out    pending_bytes[$];
    t_pat_out    mon_exp;

    // idling controls
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    bit mark_noise = 1'b0;
    int rx_hold_len = 0;

    // run statistics
    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int cfg_writes = 0;
    int pats_rewritten = 0;
    int pkts_passed = 0;

    pat_section_rewriter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // CRC-32/MPEG-2, one data bit at a time
    function automatic logic [31:0] crc_mpeg2_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[31] ^ b[k];
            c  = {c[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    // output byte for one input byte; advances the packet state
    function automatic t_pat_out pat_next_byte(input logic [7:0] b, input logic first);
        t_pat_out   r;
        logic [7:0] p;
        logic [7:0] ob;
        p  = first ? 8'd0 : pos_q;
        if (p >= PKT_LEN) p = '0;
        ob = b;

        if (p == 8'd0) begin
            rewriting_q = 1'b0;
            crc_q       = CRC_INIT;
        end else if (p == POS_PID_HI) begin
            pid_hi_q = b[4:0];
        end else if (p == POS_PID_LO) begin
            rewriting_q = (pid_hi_q == 5'd0) && (b == 8'd0) && (svc_id_q != 16'd0);
        end

        if (rewriting_q) begin
            case (p)
                POS_SEC_LEN_H: ob = BYTE_SEC_LEN_H;
                POS_SEC_LEN_L: ob = BYTE_SEC_LEN_L;
                POS_PROG0_H,
                POS_PROG0_L:   ob = 8'd0;
                POS_NIT_H:     ob = BYTE_RESV_HI;
                POS_NIT_L:     ob = BYTE_NIT_PID_L;
                POS_SVC_H:     ob = svc_id_q[15:8];
                POS_SVC_L:     ob = svc_id_q[7:0];
                POS_PMT_H:     ob = {3'b111, pmt_pid_q[12:8]};
                POS_PMT_L:     ob = pmt_pid_q[7:0];
                POS_CRC_0:     ob = crc_q[31:24];
                POS_CRC_1:     ob = crc_q[23:16];
                POS_CRC_2:     ob = crc_q[15:8];
                POS_CRC_3:     ob = crc_q[7:0];
                default: begin
                    if (p > POS_CRC_3) ob = BYTE_STUFF;
                end
            endcase
            // section bytes 5..20 feed the CRC
            if (p >= POS_CRC_START && p <= POS_PMT_L) crc_q = crc_mpeg2_step(crc_q, ob);
        end

        r.data = ob;
        r.last = (p == POS_LAST);
        r.rewr = rewriting_q;
        pos_q  = (p == POS_LAST) ? 8'd0 : p + 8'd1;
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        if (errors < 50) $display("MISMATCH at %0t ns: %s", $time, msg);
        errors++;
    endtask

    // offer one item, hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic first);
        int       gap;
        t_pat_out exp_item;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= first;
        do @(posedge i_clk); while (!o_s_tready);
        exp_item      = pat_next_byte(b, first);
        pending_bytes = {pending_bytes, exp_item};
        items_sent++;
    endtask

    // bytes [from, upto) of a packet with the given PID
    task automatic send_span(input logic [12:0] pid, input int from, input int upto,
                             input bit mark);
        logic [7:0] b;
        logic       f;
        for (int i = from; i < upto; i++) begin
            b = 8'($urandom_range(0, 255));
            f = 1'b0;
            if (i == 0) begin
                if ($urandom_range(0, 7) != 0) b = 8'h47;
                f = mark;
            end else if (i == 1) begin
                b = {b[7:5], pid[12:8]};
            end else if (i == 2) begin
                b = pid[7:0];
            end else if (mark_noise && $urandom_range(0, 255) == 0) begin
                f = 1'b1;
            end
            send_byte(b, f);
        end
    endtask

    // stop offering and wait until every expected item is out
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SERVICE_ID) svc_id_q = val;
        else pmt_pid_q = val[12:0];
        cfg_writes++;
    endtask

    // PID 0 with service id zero must pass untouched
    task automatic test_passthrough_disabled();
        write_reg(CFG_SERVICE_ID, 16'h0000);
        send_span(13'h0000, 0, PKT_LEN, 1'b1);
    endtask

    // register extremes and PID decode edges
    task automatic test_rewrite_extremes();
        write_reg(CFG_SERVICE_ID, 16'hffff);
        write_reg(CFG_PMT_PID, 16'h1fff);
        send_span(13'h0000, 0, PKT_LEN, 1'b1);
        send_span(13'h1fff, 0, 30, 1'b1);
        send_span(13'h0100, 0, 30, 1'b1);
        send_span(13'h0001, 0, 30, 1'b1);
        write_reg(CFG_SERVICE_ID, 16'h0001);
        write_reg(CFG_PMT_PID, 16'h0000);
        send_span(13'h0000, 0, 30, 1'b1);
    endtask

    // decision at byte 2, registers changed while a packet is open
    task automatic test_cfg_timing();
        write_reg(CFG_SERVICE_ID, 16'h1234);
        write_reg(CFG_PMT_PID, 16'h0abc);
        send_span(13'h0000, 0, 2, 1'b1);
        write_reg(CFG_SERVICE_ID, 16'h0000);
        send_span(13'h0000, 2, 30, 1'b1);
        write_reg(CFG_SERVICE_ID, 16'h1234);
        send_span(13'h0000, 0, 3, 1'b1);
        write_reg(CFG_SERVICE_ID, 16'h0000);
        send_span(13'h0000, 3, 18, 1'b1);
        write_reg(CFG_SERVICE_ID, 16'hbeef);
        write_reg(CFG_PMT_PID, 16'h1555);
        send_span(13'h0000, 18, 30, 1'b1);
    endtask

    // wrap without a start mark, early start marks
    task automatic test_start_marks();
        send_span(13'h0000, 0, PKT_LEN, 1'b1);
        send_span(13'h0000, 0, PKT_LEN, 1'b0);
        send_span(13'h0000, 0, 40, 1'b1);
        send_span(13'h0000, 0, 10, 1'b1);
        send_span(13'h0000, 0, 30, 1'b1);
    endtask

    // long output stall with the input offered back to back
    task automatic test_backpressure();
        tx_burst    = 1'b1;
        rx_hold_len = 80;
        send_span(13'h0000, 0, 50, 1'b1);
        settle();
        tx_burst = 1'b0;
    endtask

    // random packets until the whole run reaches its item budget
    task automatic test_random_stream();
        int         npk;
        int         len;
        int         sel;
        logic [12:0] pid;
        bit         mark;
        npk        = 0;
        mark_noise = 1'b1;
        while (items_sent < 1350) begin
            if (npk % 3 == 0) begin
                sel = $urandom_range(0, 7);
                write_reg(CFG_SERVICE_ID, (sel == 0) ? 16'h0000 :
                          (sel == 1) ? 16'hffff : 16'($urandom_range(1, 65535)));
                sel = $urandom_range(0, 5);
                write_reg(CFG_PMT_PID, (sel == 0) ? 16'h0000 :
                          (sel == 1) ? 16'h1fff : 16'($urandom_range(0, 8191)));
            end
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            pid  = ($urandom_range(0, 9) < 6) ? 13'h0000 : 13'($urandom_range(1, 8191));
            len  = ($urandom_range(0, 3) == 0) ? PKT_LEN : $urandom_range(1, 40);
            mark = ($urandom_range(0, 15) != 0);
            send_span(pid, 0, len, mark);
            npk++;
        end
        mark_noise = 1'b0;
        tx_burst   = 1'b0;
        rx_burst   = 1'b0;
    endtask

    // output side: per-item stall, one long hold when asked
    initial begin : rx_side
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold_len != 0) begin
                i_m_tready <= 1'b0;
                repeat (rx_hold_len) @(posedge i_clk);
                rx_hold_len = 0;
            end
            stall = rx_burst ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
        end
    end

    // compare each accepted output item with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_bytes.size() == 0) begin
                note_mismatch($sformatf("output item %02h with nothing expected", o_m_tdata));
            end else begin
                mon_exp = pending_bytes.pop_front();
                if (o_m_tdata !== mon_exp.data)
                    note_mismatch($sformatf("item %0d out_byte got %02h want %02h",
                                            results_checked, o_m_tdata, mon_exp.data));
                if (o_m_tlast !== mon_exp.last)
                    note_mismatch($sformatf("item %0d last_byte got %b want %b",
                                            results_checked, o_m_tlast, mon_exp.last));
                if (o_m_tuser !== mon_exp.rewr)
                    note_mismatch($sformatf("item %0d rewritten got %b want %b",
                                            results_checked, o_m_tuser, mon_exp.rewr));
                if (mon_exp.last && mon_exp.rewr) pats_rewritten++;
                if (mon_exp.last && !mon_exp.rewr) pkts_passed++;
            end
            results_checked++;
        end
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("Timeout with %0d output items still expected", pending_bytes.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_passthrough_disabled();
        test_rewrite_extremes();
        test_cfg_timing();
        test_start_marks();
        test_backpressure();
        test_random_stream();

        settle();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d bytes, checked %0d output bytes, %0d register writes.",
                 items_sent, results_checked, cfg_writes);
        $display("Full packets seen: %0d rewritten as PAT, %0d passed through.",
                 pats_rewritten, pkts_passed);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
